FILE: sv/rsla_pkg.sv
package rsla_pkg;

  // Field widths
  localparam int NOW_BITS  = 32;
  localparam int CH_BITS   = 8;
  localparam int DUR_BITS  = 16;
  localparam int MODE_BITS = 3;
  localparam int FLAG_BITS = 6;

  // Time width default
  localparam int TIME_BITS_DEF = 32;

  // Breathing level division: 255 * n with n < 2^16
  localparam int LVL_DVD_BITS = 24;

  // Divisor / remainder width of the serial divider
  localparam int DIV_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREATHE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK = 2'd3;

  localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
  localparam logic [15:0] BREATHE_RST    = 16'd2000;
  localparam logic [15:0] FAST_BLINK_RST = 16'd125;
  localparam logic [15:0] SLOW_BLINK_RST = 16'd500;

  // Display modes
  localparam logic [MODE_BITS-1:0] MODE_BOOT      = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_FAULT     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_BAD_POS   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_OFF       = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_RECONNECT = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_CONNECTED = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_AP_ONLY   = 3'd6;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_FLASH  = 1'b1;

  // Colour levels
  localparam logic [7:0] LVL_FULL  = 8'd255;
  localparam logic [7:0] LVL_AMBER = 8'd180;
  localparam logic [7:0] LVL_DIM   = 8'd80;
  localparam logic [7:0] LVL_GREEN = 8'd200;
  localparam logic [7:0] LVL_CYAN  = 8'd180;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // x / 255 for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // v * k / 255
  function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] k);
    logic [15:0] p;
    p = 16'(v) * 16'(k);
    return div255(p);
  endfunction

endpackage

FILE: sv/rsla_if.sv
interface rsla_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic        calibrating;
  logic        link_fault;
  logic        pos_valid;
  logic        net_enabled;
  logic        station_configured;
  logic        station_connected;
  logic [7:0]  flash_red;
  logic [7:0]  flash_green;
  logic [7:0]  flash_blue;
  logic [15:0] flash_duration_ms;

  modport source (
    output valid, cmd, now_ms, calibrating, link_fault, pos_valid,
           net_enabled, station_configured, station_connected,
           flash_red, flash_green, flash_blue, flash_duration_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_ms, calibrating, link_fault, pos_valid,
           net_enabled, station_configured, station_connected,
           flash_red, flash_green, flash_blue, flash_duration_ms,
    output ready
  );
endinterface

interface rsla_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       write_strobe;
  logic       overlay_active;
  logic [2:0] display_mode;

  modport source (
    output valid, red, green, blue, write_strobe, overlay_active, display_mode,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, write_strobe, overlay_active, display_mode,
    output ready
  );
endinterface

FILE: sv/rsla_serial_div.sv
module rsla_serial_div #(
  parameter int DW = rsla_pkg::TIME_BITS_DEF,
  parameter int CW = $clog2(DW + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CW-1:0]                 count,
  input  logic [DW-1:0]                 dividend,
  input  logic [rsla_pkg::DIV_BITS-1:0] divisor,
  output rsla_pkg::div_stat_t           stat,
  output logic [DW-1:0]                 quotient,
  output logic [rsla_pkg::DIV_BITS-1:0] remainder
);

  localparam int RW = rsla_pkg::DIV_BITS;

  // Restoring division, one quotient bit per cycle, dividend MSB first.
  logic [DW-1:0] dvd;
  logic [RW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [RW:0]   trial;
  logic          ge;

  assign trial = {remainder, dvd[DW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= count;
    end else if (stat.busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      quotient  <= '0;
      remainder <= '0;
    end else if (stat.busy) begin
      dvd       <= dvd << 1;
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? RW'(trial - {1'b0, dsr}) : trial[RW-1:0];
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.done) |-> $past(stat.busy))
    else $error("divider done without a run");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !stat.busy)
    else $error("divider done while still busy");

endmodule

FILE: sv/rgb_status_led_animator.sv
// Steps: a flash item, or an update that shows the overlay, goes from S_EVAL to S_DONE;
// other updates pass S_MODE and S_SCALE; boot updates also pass S_BREATHE, and with a
// breathe period of 2 or more first S_MOD and S_DIV (period modulo, then 24-bit level
// division, one bit per cycle each). One item is in work at a time.
// The output register lets the next item in while a result waits to be taken.
// Reset (synchronous, rst high): registers to their defaults, mode off, no overlay.
module rgb_status_led_animator #(
  parameter int TIME_BITS = rsla_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rsla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsla_pkg::CFG_DATA_W-1:0] cfg_data,
  rsla_req_if.sink                        req,
  rsla_rsp_if.source                      rsp
);

  localparam int LB = rsla_pkg::LVL_DVD_BITS;
  // divider datapath: wide enough for the timestamp and the level dividend
  localparam int DW = (TIME_BITS > LB) ? TIME_BITS : LB;
  localparam int CW = $clog2(DW + 1);
  localparam int MB = rsla_pkg::MODE_BITS;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EVAL    = 8'b0000_0010,  // flash / overlay decision
    S_MODE    = 8'b0000_0100,  // mode resolution and blink timing
    S_MOD     = 8'b0000_1000,  // now mod breathe period
    S_DIV     = 8'b0001_0000,  // 255*n / half
    S_BREATHE = 8'b0010_0000,  // breathing colour
    S_SCALE   = 8'b0100_0000,  // global brightness
    S_DONE    = 8'b1000_0000   // hand over to output register
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic [7:0]  brightness;
  logic [15:0] breathe_period;
  logic [15:0] fast_blink;
  logic [15:0] slow_blink;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= rsla_pkg::BRIGHTNESS_RST;
      breathe_period <= rsla_pkg::BREATHE_RST;
      fast_blink     <= rsla_pkg::FAST_BLINK_RST;
      slow_blink     <= rsla_pkg::SLOW_BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsla_pkg::REG_BRIGHTNESS: brightness     <= cfg_data[7:0];
        rsla_pkg::REG_BREATHE:    breathe_period <= cfg_data;
        rsla_pkg::REG_FAST_BLINK: fast_blink     <= cfg_data;
        rsla_pkg::REG_SLOW_BLINK: slow_blink     <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------- captured item
  logic                 cmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 boot_q, fault_q, posv_q, wifi_q, stcfg_q, stcon_q;
  logic [7:0]           fr_q, fg_q, fb_q;
  logic [15:0]          dur_q;

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      now_q   <= TIME_BITS'(req.now_ms);  // only the low TIME_BITS bits count
      boot_q  <= req.calibrating;
      fault_q <= req.link_fault;
      posv_q  <= req.pos_valid;
      wifi_q  <= req.net_enabled;
      stcfg_q <= req.station_configured;
      stcon_q <= req.station_connected;
      fr_q    <= req.flash_red;
      fg_q    <= req.flash_green;
      fb_q    <= req.flash_blue;
      dur_q   <= req.flash_duration_ms;
    end
  end

  // ------------------------------------------------------------ block state
  logic [MB-1:0]        last_mode;
  logic [TIME_BITS-1:0] anim_start;
  logic                 blink_phase;
  logic [TIME_BITS-1:0] ov_end;
  logic                 ov_valid;
  logic [7:0]           ov_r, ov_g, ov_b;
  logic [7:0]           last_r, last_g, last_b;

  // staged result
  logic [7:0]    base_r, base_g, base_b;   // unscaled colour
  logic [7:0]    res_r, res_g, res_b;
  logic          res_ov;
  logic [MB-1:0] res_mode;
  logic [7:0]    lvl;

  // ---------------------------------------------------- overlay expiry check
  logic [TIME_BITS-1:0] ov_diff;
  logic                 ov_live;
  assign ov_diff = now_q - ov_end;
  assign ov_live = ov_valid && ov_diff[TIME_BITS-1];  // end time not yet reached

  // -------------------------------------------------------- mode resolution
  logic [MB-1:0] mode;
  always_comb begin
    priority if (boot_q)            mode = rsla_pkg::MODE_BOOT;
    else if (fault_q)               mode = rsla_pkg::MODE_FAULT;
    else if (!posv_q)               mode = rsla_pkg::MODE_BAD_POS;
    else if (!wifi_q)               mode = rsla_pkg::MODE_OFF;
    else if (stcfg_q && !stcon_q)   mode = rsla_pkg::MODE_RECONNECT;
    else if (stcfg_q)               mode = rsla_pkg::MODE_CONNECTED;
    else                            mode = rsla_pkg::MODE_AP_ONLY;
  end

  // blink timing; a mode change restarts the timer before the tick check
  logic                 mode_chg;
  logic [TIME_BITS-1:0] eff_start;
  logic                 eff_phase;
  logic [TIME_BITS-1:0] blink_d;
  logic [15:0]          half_per;
  logic                 blinking;
  logic                 tick;
  logic                 new_phase;

  assign mode_chg  = (mode != last_mode);
  assign eff_start = mode_chg ? now_q : anim_start;
  assign eff_phase = mode_chg ? 1'b0 : blink_phase;
  assign blink_d   = now_q - eff_start;
  assign half_per  = (mode == rsla_pkg::MODE_FAULT) ? fast_blink : slow_blink;
  assign blinking  = (mode == rsla_pkg::MODE_FAULT) || (mode == rsla_pkg::MODE_BAD_POS) ||
                     (mode == rsla_pkg::MODE_RECONNECT);
  // negative difference never ticks
  assign tick      = blinking && !blink_d[TIME_BITS-1] &&
                     (blink_d >= TIME_BITS'(half_per));
  assign new_phase = eff_phase ^ tick;

  // unscaled colour of the resolved mode; boot gets its colour in S_BREATHE
  logic [7:0] base_r_next, base_g_next, base_b_next;
  always_comb begin
    base_r_next = '0;
    base_g_next = '0;
    base_b_next = '0;
    unique case (mode)
      rsla_pkg::MODE_FAULT: if (new_phase) begin
        base_r_next = rsla_pkg::LVL_FULL;
        base_b_next = rsla_pkg::LVL_FULL;
      end
      rsla_pkg::MODE_BAD_POS: if (new_phase) begin
        base_r_next = rsla_pkg::LVL_FULL;
        base_g_next = rsla_pkg::LVL_DIM;
      end
      rsla_pkg::MODE_RECONNECT: if (new_phase) begin
        base_b_next = rsla_pkg::LVL_FULL;
        base_g_next = rsla_pkg::LVL_DIM;
      end
      rsla_pkg::MODE_CONNECTED: base_g_next = rsla_pkg::LVL_GREEN;
      rsla_pkg::MODE_AP_ONLY: begin
        base_g_next = rsla_pkg::LVL_CYAN;
        base_b_next = rsla_pkg::LVL_CYAN;
      end
      default: ;  // off, boot
    endcase
  end

  // ---------------------------------------------------------- serial divider
  logic                 div_start;
  logic [CW-1:0]        div_count;
  logic [DW-1:0]        div_dvd;
  logic [15:0]          div_dsr;
  rsla_pkg::div_stat_t  div_stat;
  logic [DW-1:0]        div_quo;
  logic [15:0]          div_rem;

  logic [14:0]   half_breathe;
  logic          breathe_on;
  logic [15:0]   tri_n;      // distance to nearest trough of the triangle
  logic [LB-1:0] lvl_dvd;    // 255 * tri_n

  assign half_breathe = breathe_period[15:1];
  assign breathe_on   = (half_breathe != 15'd0);
  assign tri_n        = (div_rem < {1'b0, half_breathe}) ? div_rem : breathe_period - div_rem;
  assign lvl_dvd      = {tri_n, 8'd0} - LB'(tri_n);

  always_comb begin
    div_start = 1'b0;
    div_count = CW'(TIME_BITS);
    div_dvd   = DW'(now_q) << (DW - TIME_BITS);   // MSB-aligned
    div_dsr   = breathe_period;
    unique case (state)
      S_MODE: div_start = (mode == rsla_pkg::MODE_BOOT) && breathe_on;
      S_MOD: begin
        div_start = div_stat.done;
        div_count = CW'(LB);
        div_dvd   = DW'(lvl_dvd) << (DW - LB);
        div_dsr   = {1'b0, half_breathe};
      end
      S_IDLE, S_EVAL, S_DIV, S_BREATHE, S_SCALE, S_DONE: ;
    endcase
  end

  rsla_serial_div #(.DW(DW), .CW(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .count     (div_count),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // odd periods can push the level past full scale
  logic [7:0] lvl_sat;
  assign lvl_sat = (div_quo > DW'(255)) ? rsla_pkg::LVL_FULL : div_quo[7:0];

  // ------------------------------------------------------------- output side
  logic load_out;
  logic strobe;
  assign load_out = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign strobe   = (res_r != last_r) || (res_g != last_g) || (res_b != last_b);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_mode   <= rsla_pkg::MODE_OFF;
      anim_start  <= '0;
      blink_phase <= 1'b0;
      ov_end      <= '0;
      ov_valid    <= 1'b0;
      ov_r        <= '0;
      ov_g        <= '0;
      ov_b        <= '0;
      last_r      <= '0;
      last_g      <= '0;
      last_b      <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_EVAL;

        S_EVAL: begin
          res_mode <= last_mode;
          res_ov   <= 1'b1;
          if (cmd_q == rsla_pkg::CMD_FLASH) begin
            // overlay shown unscaled, animation state untouched
            ov_r     <= fr_q;
            ov_g     <= fg_q;
            ov_b     <= fb_q;
            ov_end   <= now_q + TIME_BITS'(dur_q);
            ov_valid <= 1'b1;
            res_r    <= fr_q;
            res_g    <= fg_q;
            res_b    <= fb_q;
            state    <= S_DONE;
          end else if (ov_live) begin
            res_r <= ov_r;
            res_g <= ov_g;
            res_b <= ov_b;
            state <= S_DONE;
          end else begin
            ov_valid <= 1'b0;
            state    <= S_MODE;
          end
        end

        S_MODE: begin
          last_mode   <= mode;
          res_mode    <= mode;
          res_ov      <= 1'b0;
          blink_phase <= new_phase;
          anim_start  <= (mode_chg || tick) ? now_q : anim_start;
          base_r      <= base_r_next;
          base_g      <= base_g_next;
          base_b      <= base_b_next;
          lvl         <= rsla_pkg::LVL_FULL;
          // boot: breathing level first, or full level for a short period
          if (mode == rsla_pkg::MODE_BOOT) begin
            state <= breathe_on ? S_MOD : S_BREATHE;
          end else begin
            state <= S_SCALE;
          end
        end

        S_MOD: if (div_stat.done) state <= S_DIV;

        S_DIV: if (div_stat.done) begin
          lvl   <= lvl_sat;
          state <= S_BREATHE;
        end

        S_BREATHE: begin
          // amber scaled by the breathing level; 255*lvl/255 is lvl itself
          base_r <= lvl;
          base_g <= rsla_pkg::scale8(rsla_pkg::LVL_AMBER, lvl);
          base_b <= '0;
          state  <= S_SCALE;
        end

        S_SCALE: begin
          res_r <= rsla_pkg::scale8(base_r, brightness);
          res_g <= rsla_pkg::scale8(base_g, brightness);
          res_b <= rsla_pkg::scale8(base_b, brightness);
          state <= S_DONE;
        end

        S_DONE: if (load_out) begin
          last_r <= res_r;
          last_g <= res_g;
          last_b <= res_b;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.red            <= res_r;
      rsp.green          <= res_g;
      rsp.blue           <= res_b;
      rsp.write_strobe   <= strobe;
      rsp.overlay_active <= res_ov;
      rsp.display_mode   <= res_mode;
    end
  end

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second item taken while one is in work");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!rsp.valid || rsp.ready))
    else $error("waiting result overwritten");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid &&
      $stable({rsp.red, rsp.green, rsp.blue, rsp.write_strobe, rsp.overlay_active,
               rsp.display_mode}))
    else $error("waiting result changed");

endmodule
